@@ rtl/core/hbd_pkg.sv @@
// ----------------------------------------------------------------------------
// hbd_pkg
// Types, codes and character helpers for the HTTP body deframer.
// ----------------------------------------------------------------------------
package hbd_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } hbd_in_t;

  typedef struct packed {
    logic [7:0] payload;
    logic       payload_valid;
    logic       body_done;
    logic       after_end;
  } hbd_out_t;

  localparam logic       CMD_DATA  = 1'b0;
  localparam logic       CMD_START = 1'b1;

  localparam int unsigned CFG_INDEX_WIDTH = 1;
  localparam int unsigned CFG_DATA_WIDTH  = 32;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BODY_MODE      = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CONTENT_LENGTH = 1'd1;

  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_LENGTH  = 2'd1;
  localparam logic [1:0] MODE_CHUNKED = 2'd2;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [7:0] CHAR_UP_X  = 8'h58;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_F  = 8'h66;
  localparam logic [7:0] CHAR_LO_X  = 8'h78;

  localparam int unsigned DIGIT_BITS = 4;

  typedef enum logic [3:0] {
    PH_COMPLETE = 4'b0001,
    PH_SIZE     = 4'b0010,
    PH_DATA     = 4'b0100,
    PH_TRAILER  = 4'b1000
  } hbd_phase_t;

  typedef enum logic [4:0] {
    SS_BLANKS  = 5'b00001,
    SS_ZERO    = 5'b00010,
    SS_PREFIX  = 5'b00100,
    SS_DIGITS  = 5'b01000,
    SS_STOPPED = 5'b10000
  } hbd_sub_t;

  // {is_hex, value}
  function automatic logic [DIGIT_BITS:0] hex_decode(input logic [7:0] c);
    logic [DIGIT_BITS:0] r;
    r = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r = {1'b1, 4'(c - CHAR_ZERO)};
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
      r = {1'b1, 4'(c - CHAR_LO_A + 8'd10)};
    end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
      r = {1'b1, 4'(c - CHAR_UP_A + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
           (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
  endfunction

endpackage

@@ rtl/core/hbd_size_parser.sv @@
// ----------------------------------------------------------------------------
// hbd_size_parser
// One character step of the chunk size line: blanks, optional 0x, hex digits
// with a saturating accumulator.
// ----------------------------------------------------------------------------
module hbd_size_parser import hbd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  hbd_sub_t               sub,
  input  logic [COUNT_WIDTH-1:0] acc,
  input  logic [7:0]             chr,
  output hbd_sub_t               sub_next,
  output logic [COUNT_WIDTH-1:0] acc_next
);

  logic [DIGIT_BITS:0]    hex;
  logic                   is_hex;
  logic [DIGIT_BITS-1:0]  digit;
  logic [COUNT_WIDTH-1:0] acc_add;

  assign hex    = hex_decode(chr);
  assign is_hex = hex[DIGIT_BITS];
  assign digit  = hex[DIGIT_BITS-1:0];

  // top nibble set means the shift would overflow
  assign acc_add = (|acc[COUNT_WIDTH-1 -: DIGIT_BITS]) ? '1 :
                   {acc[COUNT_WIDTH-DIGIT_BITS-1:0], digit};

  always_comb begin
    sub_next = sub;
    acc_next = acc;
    case (sub)
      SS_BLANKS: begin
        if (is_blank(chr)) begin
          sub_next = SS_BLANKS;
        end else if (chr == CHAR_ZERO) begin
          sub_next = SS_ZERO;
        end else if (is_hex) begin
          acc_next = COUNT_WIDTH'(digit);
          sub_next = SS_DIGITS;
        end else begin
          sub_next = SS_STOPPED;
        end
      end
      SS_ZERO: begin
        if (chr == CHAR_LO_X || chr == CHAR_UP_X) begin
          sub_next = SS_PREFIX;
        end else if (is_hex) begin
          acc_next = acc_add;
          sub_next = SS_DIGITS;
        end else begin
          sub_next = SS_STOPPED;
        end
      end
      SS_PREFIX, SS_DIGITS: begin
        if (is_hex) begin
          acc_next = acc_add;
          sub_next = SS_DIGITS;
        end else begin
          sub_next = SS_STOPPED;
        end
      end
      default: begin
        sub_next = sub;
      end
    endcase
  end

endmodule

@@ rtl/core/hbd_core.sv @@
// ----------------------------------------------------------------------------
// hbd_core
// Framing state and per-byte classification; state advances on step.
// ----------------------------------------------------------------------------
module hbd_core import hbd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  hbd_in_t                   item,
  input  logic [1:0]                body_mode,
  input  logic [CFG_DATA_WIDTH-1:0] content_length,
  output hbd_out_t                  result
);

  hbd_phase_t             phase, phase_next;
  logic                   chunked, chunked_next;
  hbd_sub_t               sub, sub_next;
  logic                   pending_cr, pending_cr_next;
  logic [COUNT_WIDTH-1:0] bytes_remaining, bytes_remaining_next;
  logic [COUNT_WIDTH-1:0] size_acc, size_acc_next;

  logic [COUNT_WIDTH-1:0] start_len;
  logic [COUNT_WIDTH-1:0] rem_dec;
  logic [7:0]             chr;
  logic                   line_end;
  hbd_sub_t               sub_cr;
  hbd_sub_t               sub_fed;
  logic [COUNT_WIDTH-1:0] acc_fed;

  generate
    if (COUNT_WIDTH >= CFG_DATA_WIDTH) begin : g_len_wide
      assign start_len = COUNT_WIDTH'(content_length);
    end else begin : g_len_sat
      assign start_len = (|content_length[CFG_DATA_WIDTH-1:COUNT_WIDTH]) ? '1 :
                         content_length[COUNT_WIDTH-1:0];
    end
  endgenerate

  assign chr      = item.data_byte;
  assign line_end = pending_cr && (chr == CHAR_LF);
  assign rem_dec  = (bytes_remaining == '0) ? '0 : bytes_remaining - 1'b1;

  // a held CR that is not a line end is a plain character: stops any number
  assign sub_cr = (pending_cr && sub != SS_BLANKS) ? SS_STOPPED : sub;

  hbd_size_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_size_parser (
    .sub      (sub_cr),
    .acc      (size_acc),
    .chr      (chr),
    .sub_next (sub_fed),
    .acc_next (acc_fed)
  );

  always_comb begin
    phase_next           = phase;
    chunked_next         = chunked;
    sub_next             = sub;
    pending_cr_next      = pending_cr;
    bytes_remaining_next = bytes_remaining;
    size_acc_next        = size_acc;
    result               = '0;
    if (item.cmd == CMD_START) begin
      sub_next             = SS_BLANKS;
      pending_cr_next      = 1'b0;
      size_acc_next        = '0;
      bytes_remaining_next = '0;
      chunked_next         = 1'b0;
      case (body_mode)
        MODE_LENGTH: begin
          bytes_remaining_next = start_len;
          if (start_len == '0) begin
            phase_next       = PH_COMPLETE;
            result.body_done = 1'b1;
          end else begin
            phase_next = PH_DATA;
          end
        end
        MODE_CHUNKED: begin
          chunked_next = 1'b1;
          phase_next   = PH_SIZE;
        end
        default: begin
          phase_next       = PH_COMPLETE;
          result.body_done = 1'b1;
        end
      endcase
    end else begin
      case (phase)
        PH_COMPLETE: begin
          result.after_end = 1'b1;
        end
        PH_DATA: begin
          result.payload       = chr;
          result.payload_valid = 1'b1;
          bytes_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            if (chunked) begin
              phase_next      = PH_TRAILER;
              sub_next        = SS_BLANKS;
              pending_cr_next = 1'b0;
              size_acc_next   = '0;
            end else begin
              phase_next       = PH_COMPLETE;
              result.body_done = 1'b1;
            end
          end
        end
        PH_SIZE, PH_TRAILER: begin
          if (line_end) begin
            sub_next        = SS_BLANKS;
            pending_cr_next = 1'b0;
            size_acc_next   = '0;
            if (phase == PH_SIZE) begin
              if (size_acc == '0) begin
                phase_next       = PH_COMPLETE;
                result.body_done = 1'b1;
              end else begin
                bytes_remaining_next = size_acc;
                phase_next           = PH_DATA;
              end
            end else begin
              phase_next = PH_SIZE;
            end
          end else begin
            pending_cr_next = (chr == CHAR_CR);
            if (phase == PH_SIZE) begin
              if (chr == CHAR_CR) begin
                sub_next = sub_cr;
              end else begin
                sub_next      = sub_fed;
                size_acc_next = acc_fed;
              end
            end
          end
        end
        default: begin
          phase_next = PH_COMPLETE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_COMPLETE;
      chunked         <= 1'b0;
      sub             <= SS_BLANKS;
      pending_cr      <= 1'b0;
      bytes_remaining <= '0;
      size_acc        <= '0;
    end else if (step) begin
      phase           <= phase_next;
      chunked         <= chunked_next;
      sub             <= sub_next;
      pending_cr      <= pending_cr_next;
      bytes_remaining <= bytes_remaining_next;
      size_acc        <= size_acc_next;
    end
  end

endmodule

@@ rtl/core/http_body_deframer.sv @@
// ----------------------------------------------------------------------------
// http_body_deframer
// Marks payload bytes of an HTTP request body in none, length and chunked modes.
// Path: input register feeds framing logic, whose marks go to the result register.
// Throughput: one request per cycle while the output is not stalled; the
// result register holds the output while it is stalled.
// Reset: synchronous; framing returns to body complete, valid flags and config cleared.
// ----------------------------------------------------------------------------
module http_body_deframer import hbd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  hbd_in_t                    in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output hbd_out_t                   out_data
);

  logic [1:0]                body_mode;
  logic [CFG_DATA_WIDTH-1:0] content_length;
  logic                      hold_valid;
  hbd_in_t                   hold_data;
  logic                      advance;
  hbd_out_t                  core_result;

  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_mode      <= MODE_NONE;
      content_length <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BODY_MODE:      body_mode      <= cfg_data[1:0];
        CFG_CONTENT_LENGTH: content_length <= cfg_data;
        default:            body_mode      <= body_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_data <= in_data;
    end
  end

  hbd_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .item           (hold_data),
    .body_mode      (body_mode),
    .content_length (content_length),
    .result         (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= core_result;
    end
  end

endmodule

@@ bench/hbd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_checker
// Watches the request, result and register ports of the body deframer, keeps
// its own framing state, predicts the marks for every accepted request and
// compares them in order with the accepted results.
// ----------------------------------------------------------------------------
module hbd_checker import hbd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  hbd_in_t                    in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  hbd_out_t                   out_data,
  output int                         mismatches,
  output int                         open_results
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [1:0]             mode_reg;
  logic [31:0]            length_reg;
  hbd_phase_t             phase;
  logic                   in_chunk;
  hbd_sub_t               sub;
  logic                   cr_seen;
  logic [COUNT_WIDTH-1:0] remaining;
  logic [COUNT_WIDTH-1:0] size_acc;
  hbd_out_t               predicted_marks[$];
  hbd_out_t               want;

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
    if (c >= CHAR_LO_A && c <= CHAR_LO_F) return int'(c - CHAR_LO_A) + 10;
    if (c >= CHAR_UP_A && c <= CHAR_UP_F) return int'(c - CHAR_UP_A) + 10;
    return -1;
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return c inside {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
  endfunction

  // saturating accumulate of one hex digit
  function automatic void shift_digit(input int d);
    logic [COUNT_WIDTH-1:0] dv;
    dv = COUNT_WIDTH'(d);
    if (size_acc > ((COUNT_MAX - dv) >> DIGIT_BITS)) size_acc = COUNT_MAX;
    else size_acc = (size_acc << DIGIT_BITS) + dv;
  endfunction

  function automatic void size_char(input logic [7:0] c);
    int d;
    d = hex_digit(c);
    case (sub)
      SS_BLANKS: begin
        if (!blank_char(c)) begin
          if (c == CHAR_ZERO) begin
            sub = SS_ZERO;
          end else if (d >= 0) begin
            size_acc = COUNT_WIDTH'(d);
            sub = SS_DIGITS;
          end else begin
            sub = SS_STOPPED;
          end
        end
      end
      SS_ZERO: begin
        if (c == CHAR_LO_X || c == CHAR_UP_X) begin
          sub = SS_PREFIX;
        end else if (d >= 0) begin
          shift_digit(d);
          sub = SS_DIGITS;
        end else begin
          sub = SS_STOPPED;
        end
      end
      SS_PREFIX, SS_DIGITS: begin
        if (d >= 0) begin
          shift_digit(d);
          sub = SS_DIGITS;
        end else begin
          sub = SS_STOPPED;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void clear_line();
    cr_seen = 1'b0;
    sub = SS_BLANKS;
    size_acc = '0;
  endfunction

  function automatic hbd_out_t mark_byte(input hbd_in_t req);
    hbd_out_t               r;
    logic                   line_end;
    logic [COUNT_WIDTH-1:0] sz;
    r = '0;
    if (req.cmd == CMD_START) begin
      clear_line();
      remaining = '0;
      in_chunk = 1'b0;
      case (mode_reg)
        MODE_LENGTH: begin
          if (64'(length_reg) > 64'(COUNT_MAX)) remaining = COUNT_MAX;
          else remaining = COUNT_WIDTH'(length_reg);
          if (remaining == '0) begin
            phase = PH_COMPLETE;
            r.body_done = 1'b1;
          end else begin
            phase = PH_DATA;
          end
        end
        MODE_CHUNKED: begin
          in_chunk = 1'b1;
          phase = PH_SIZE;
        end
        default: begin
          phase = PH_COMPLETE;
          r.body_done = 1'b1;
        end
      endcase
    end else if (phase == PH_COMPLETE) begin
      r.after_end = 1'b1;
    end else if (phase == PH_DATA) begin
      r.payload = req.data_byte;
      r.payload_valid = 1'b1;
      if (remaining != '0) remaining = remaining - 1'b1;
      if (remaining == '0) begin
        if (in_chunk) begin
          phase = PH_TRAILER;
          clear_line();
        end else begin
          phase = PH_COMPLETE;
          r.body_done = 1'b1;
        end
      end
    end else begin
      line_end = 1'b0;
      if (cr_seen) begin
        cr_seen = 1'b0;
        if (req.data_byte == CHAR_LF) line_end = 1'b1;
        else if (phase == PH_SIZE) size_char(CHAR_CR);
      end
      if (!line_end) begin
        if (req.data_byte == CHAR_CR) cr_seen = 1'b1;
        else if (phase == PH_SIZE) size_char(req.data_byte);
      end else if (phase == PH_SIZE) begin
        sz = size_acc;
        clear_line();
        if (sz == '0) begin
          phase = PH_COMPLETE;
          r.body_done = 1'b1;
        end else begin
          remaining = sz;
          phase = PH_DATA;
        end
      end else begin
        clear_line();
        phase = PH_SIZE;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode_reg = MODE_NONE;
      length_reg = '0;
      phase = PH_COMPLETE;
      in_chunk = 1'b0;
      clear_line();
      remaining = '0;
      predicted_marks.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_marks.size() == 0) begin
          mismatches++;
          $error("result with no request pending: payload %0h", out_data.payload);
        end else begin
          want = predicted_marks.pop_front();
          if (out_data.payload !== want.payload) begin
            mismatches++;
            $error("payload: expected %0h, got %0h", want.payload, out_data.payload);
          end
          if (out_data.payload_valid !== want.payload_valid) begin
            mismatches++;
            $error("payload_valid: expected %0b, got %0b",
                   want.payload_valid, out_data.payload_valid);
          end
          if (out_data.body_done !== want.body_done) begin
            mismatches++;
            $error("body_done: expected %0b, got %0b", want.body_done, out_data.body_done);
          end
          if (out_data.after_end !== want.after_end) begin
            mismatches++;
            $error("after_end: expected %0b, got %0b", want.after_end, out_data.after_end);
          end
        end
      end
      if (in_valid && !in_stall) predicted_marks.push_back(mark_byte(in_data));
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BODY_MODE:      mode_reg = cfg_data[1:0];
          CFG_CONTENT_LENGTH: length_reg = cfg_data;
          default: ;
        endcase
      end
    end
    open_results = predicted_marks.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the body deframer with directed bodies in every mode, then random
// chunked, length and empty bodies with malformed lines, overflowing sizes,
// truncation and stray bytes, under random idling, stalls and one long
// result hold-off. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import hbd_pkg::*;

  localparam int ITEMS       = 1550;
  localparam int LIMIT       = 200000;
  localparam int SETTLE      = 4;
  localparam int TAIL        = 10;
  localparam int HOLD_CYCLES = 80;
  localparam int PRESSURE_PH = 5;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  hbd_in_t                    in_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  hbd_out_t                   out_data;
  int                         mismatches;
  int                         open_results;

  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  int          sent = 0;
  int          cycles = 0;
  logic [31:0] cur_len = '0;
  logic [7:0]  txq[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  http_body_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  hbd_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .open_results (open_results)
  );

  task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    cfg_write(CFG_BODY_MODE, {30'($urandom), m});
  endtask

  task automatic set_length(input logic [31:0] len);
    cur_len = len;
    cfg_write(CFG_CONTENT_LENGTH, len);
  endtask

  task automatic send(input logic cmd, input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {cmd, b};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic start_body();
    send(CMD_START, 8'($urandom));
  endtask

  task automatic send_txq();
    while (txq.size() > 0) send(CMD_DATA, txq.pop_front());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    if (nib < 4'd10) return CHAR_ZERO + 8'(nib);
    return (upper ? CHAR_UP_A : CHAR_LO_A) + 8'(nib) - 8'd10;
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) txq.push_back(s[i]);
  endfunction

  function automatic void put_crlf();
    txq.push_back(CHAR_CR);
    txq.push_back(CHAR_LF);
  endfunction

  function automatic void put_hex(input logic [31:0] v, input logic upper);
    int top;
    top = 7;
    while (top > 0 && v[top*4 +: 4] == 4'd0) top--;
    for (int i = top; i >= 0; i--) txq.push_back(hex_char(v[i*4 +: 4], upper));
  endfunction

  function automatic void put_size_line(input logic [31:0] v);
    repeat ($urandom_range(2)) begin
      case ($urandom_range(4))
        0: txq.push_back(CHAR_SPACE);
        1: txq.push_back(CHAR_TAB);
        2: txq.push_back(CHAR_VT);
        3: txq.push_back(CHAR_FF);
        default: txq.push_back(CHAR_LF);
      endcase
    end
    // lone CR counts as a blank here
    if ($urandom_range(9) == 0) begin
      txq.push_back(CHAR_CR);
      txq.push_back(CHAR_SPACE);
    end
    case ($urandom_range(3))
      0: ;
      1: put_str("0x");
      2: put_str("0X");
      default: repeat ($urandom_range(1, 2)) txq.push_back(CHAR_ZERO);
    endcase
    put_hex(v, 1'($urandom_range(1)));
    case ($urandom_range(4))
      0: put_str(";name=val");
      1: txq.push_back(CHAR_SPACE);
      2: begin
        txq.push_back(CHAR_CR);
        put_str("x");
      end
      default: ;
    endcase
    put_crlf();
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(5))
      0: return CHAR_CR;
      1: return CHAR_LF;
      2: return CHAR_ZERO;
      3: return CHAR_LO_X;
      4: return CHAR_SPACE;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void put_overflow_line();
    txq.push_back(hex_char(4'd1, 1'b0));
    repeat (9) txq.push_back(hex_char(4'($urandom), 1'($urandom_range(1))));
    put_crlf();
  endfunction

  function automatic void build_chunked(input int max_sz);
    int         sz;
    logic [7:0] b;
    repeat ($urandom_range(3)) begin
      sz = $urandom_range(1, max_sz);
      put_size_line(sz);
      repeat (sz) txq.push_back(8'($urandom));
      repeat ($urandom_range(2)) begin
        do b = 8'($urandom); while (b == CHAR_CR);
        txq.push_back(b);
      end
      put_crlf();
    end
    case ($urandom_range(4))
      0: put_str("-5");
      1: put_str("+1a");
      2: put_str("g1");
      3: ;
      default: put_size_line(0);
    endcase
    if (txq.size() == 0 || txq[txq.size()-1] != CHAR_LF) put_crlf();
  endfunction

  function automatic void build_length(input logic [31:0] len);
    int n;
    n = (len <= 64) ? int'(len) : $urandom_range(5, 20);
    repeat (n) txq.push_back(8'($urandom));
  endfunction

  function automatic void break_up();
    int cut;
    case ($urandom_range(3))
      0: begin
        if (txq.size() > 0) begin
          cut = $urandom_range(txq.size() - 1);
          while (txq.size() > cut) void'(txq.pop_back());
        end
      end
      1: if (txq.size() > 0) txq[$urandom_range(txq.size() - 1)] = noise_byte();
      2: begin
        txq.delete();
        put_overflow_line();
        repeat ($urandom_range(3, 10)) txq.push_back(8'($urandom));
      end
      default: repeat ($urandom_range(1, 12)) txq.push_back(noise_byte());
    endcase
  endfunction

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 21);
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int          phase_no;
    int          r;
    logic [1:0]  mode;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset state, every mode, zero and maximum lengths
    send(CMD_DATA, 8'hFF);
    start_body();
    settle();
    set_mode(MODE_LENGTH);
    set_length(32'd0);
    start_body();
    send(CMD_DATA, 8'h00);
    settle();
    set_length(32'd3);
    start_body();
    send(CMD_DATA, 8'h00);
    send(CMD_DATA, 8'hFF);
    send(CMD_DATA, 8'h5A);
    settle();
    set_length(32'hFFFF_FFFF);
    start_body();
    send(CMD_DATA, CHAR_CR);
    send(CMD_DATA, CHAR_LF);
    settle();
    set_mode(2'd3);
    start_body();
    settle();
    set_mode(MODE_CHUNKED);
    start_body();
    txq.push_back(CHAR_ZERO + 8'd2);
    put_crlf();
    txq.push_back(8'h80);
    txq.push_back(8'h7F);
    put_crlf();
    txq.push_back(CHAR_ZERO);
    put_crlf();
    send_txq();

    phase_no = 0;
    while (sent < ITEMS) begin
      settle();
      quiet = (phase_no >= 20 && phase_no < 30);
      r = $urandom_range(99);
      if (r < 50) mode = MODE_CHUNKED;
      else if (r < 80) mode = MODE_LENGTH;
      else if (r < 90) mode = MODE_NONE;
      else mode = 2'd3;
      if (phase_no == PRESSURE_PH) mode = MODE_CHUNKED;
      set_mode(mode);
      if (mode == MODE_LENGTH || $urandom_range(3) == 0) begin
        case ($urandom_range(19))
          0: set_length(32'hFFFF_FFFF);
          1: set_length($urandom);
          2: set_length(32'd0);
          default: set_length($urandom_range(1, 30));
        endcase
      end
      if (phase_no == PRESSURE_PH) hold_req = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        start_body();
        txq.delete();
        case (mode)
          MODE_CHUNKED: begin
            if (phase_no == PRESSURE_PH) build_chunked(60);
            else build_chunked(($urandom_range(9) == 0) ? 40 : 12);
          end
          MODE_LENGTH: build_length(cur_len);
          default: ;
        endcase
        repeat ($urandom_range(2)) txq.push_back(8'($urandom));
        if ($urandom_range(99) < 20) break_up();
        send_txq();
      end
      phase_no++;
    end

    in_valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
